FILE: src/rot_pkg.sv
// Shared types, constants and helpers for the relay autotune oscillation observer.
// No dependencies; used by every module under src.
package rot_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	localparam int SP_W      = 16;
	localparam int BW_W      = 8;
	localparam int TO_W      = 16;
	localparam int TICK_W    = 16;
	localparam int PHASE_W   = 3;
	localparam int BAND_W    = 17;
	localparam int INTEG_W   = 16;
	localparam int DERIV_W   = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// register reset values
	localparam logic signed [SP_W-1:0] SP_RST = 16'sd0;
	localparam logic [BW_W-1:0]        BW_RST = 8'd4;
	localparam logic [TO_W-1:0]        TO_RST = 16'd2000;

	// x/10 == (x * 0xCCCD) >> 19 for every 16-bit x
	localparam logic [TICK_W-1:0] DIV10_MUL   = 16'hCCCD;
	localparam int                DIV10_SHIFT = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_POINT  = 2'd0,
		CFG_BAND_WIDTH = 2'd1,
		CFG_TIMEOUT    = 2'd2
	} cfg_idx_t;

	// external phase codes
	localparam logic [PHASE_W-1:0] PH_ARM_HI    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ARM_LO    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_TRACK_MIN = 3'd2;
	localparam logic [PHASE_W-1:0] PH_TRACK_MAX = 3'd3;
	localparam logic [PHASE_W-1:0] PH_TIME_LOW  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DONE      = 3'd5;
	localparam logic [PHASE_W-1:0] PH_ERROR     = 3'd6;

	typedef enum logic [6:0] {
		ST_ARM_HI    = 7'b0000001,
		ST_ARM_LO    = 7'b0000010,
		ST_TRACK_MIN = 7'b0000100,
		ST_TRACK_MAX = 7'b0001000,
		ST_TIME_LOW  = 7'b0010000,
		ST_DONE      = 7'b0100000,
		ST_ERROR     = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               tune_valid;
		logic [BAND_W-1:0]  band;
		logic [INTEG_W-1:0] integ;
		logic [DERIV_W-1:0] deriv;
	} result_t;

	function automatic logic [PHASE_W-1:0] phase_code(input state_t st);
		logic [PHASE_W-1:0] code;
		case (st)
			ST_ARM_HI:    code = PH_ARM_HI;
			ST_ARM_LO:    code = PH_ARM_LO;
			ST_TRACK_MIN: code = PH_TRACK_MIN;
			ST_TRACK_MAX: code = PH_TRACK_MAX;
			ST_TIME_LOW:  code = PH_TIME_LOW;
			ST_DONE:      code = PH_DONE;
			default:      code = PH_ERROR;
		endcase
		return code;
	endfunction

endpackage

FILE: src/rot_cfg_regs.sv
// Configuration registers and the crossing thresholds derived from them.
// Depends on rot_pkg.
module rot_cfg_regs import rot_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int TW = ((SAMPLE_BITS > SP_W) ? SAMPLE_BITS : SP_W) + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic signed [TW-1:0] hi_thr,
	output logic signed [TW-1:0] lo_thr,
	output logic [TO_W-1:0]      timeout
);

	logic signed [SP_W-1:0] sp_q;
	logic [BW_W-1:0]        bw_q;
	logic [TO_W-1:0]        to_q;
	logic signed [TW-1:0]   sp_ext;
	logic signed [TW-1:0]   half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= SP_RST;
			bw_q <= BW_RST;
			to_q <= TO_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SET_POINT:  sp_q <= cfg_data[SP_W-1:0];
				CFG_BAND_WIDTH: bw_q <= cfg_data[BW_W-1:0];
				CFG_TIMEOUT:    to_q <= cfg_data[TO_W-1:0];
				default: ;
			endcase
		end
	end

	assign sp_ext = {{(TW-SP_W){sp_q[SP_W-1]}}, sp_q};
	assign half   = {{(TW-BW_W+1){1'b0}}, bw_q[BW_W-1:1]};

	// thresholds follow the registers directly, like the timeout
	assign hi_thr  = sp_ext + half;
	assign lo_thr  = sp_ext - half;
	assign timeout = to_q;

endmodule

FILE: src/rot_phase_ctrl.sv
// Phase sequencer: peak tracking, tick timer and tuning result for one word.
// Depends on rot_pkg.
module rot_phase_ctrl import rot_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int TW = ((SAMPLE_BITS > SP_W) ? SAMPLE_BITS : SP_W) + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   cmd,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic signed [TW-1:0]   hi_thr,
	input  logic signed [TW-1:0]   lo_thr,
	input  logic [TO_W-1:0]        timeout,
	output result_t                res
);

	localparam int DW = ((SAMPLE_BITS + 1) > BAND_W) ? (SAMPLE_BITS + 1) : BAND_W;

	state_t                        state_q, state_d;
	logic signed [SAMPLE_BITS-1:0] ext_q, ext_d;
	logic signed [SAMPLE_BITS-1:0] low_q, low_d;
	logic signed [SAMPLE_BITS-1:0] high_q, high_d;
	logic [TICK_W-1:0]             tick_q, tick_d;

	logic signed [SAMPLE_BITS-1:0] s;
	logic signed [TW-1:0]          s_ext;
	logic                          above, below, timed_out;
	logic signed [DW-1:0]          diff;
	logic [2*TICK_W-1:0]           prod;

	assign s         = sample;
	assign s_ext     = {{(TW-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
	assign above     = s_ext >= hi_thr;
	assign below     = s_ext <= lo_thr;
	assign timed_out = tick_q >= timeout;
	assign diff      = DW'(high_q) - DW'(low_q);
	assign prod      = {{TICK_W{1'b0}}, tick_q} * {{TICK_W{1'b0}}, DIV10_MUL};

	always_comb begin
		state_d        = state_q;
		ext_d          = ext_q;
		low_d          = low_q;
		high_d         = high_q;
		tick_d         = tick_q;
		res.tune_valid = 1'b0;
		res.band       = '0;
		res.integ      = '0;
		res.deriv      = '0;
		if (cmd) begin
			if (!timed_out) begin
				tick_d = tick_q + TICK_W'(1);
			end
		end else if (state_q != ST_DONE && state_q != ST_ERROR) begin
			if (timed_out) begin
				state_d = ST_ERROR;
			end else begin
				case (state_q)
					ST_ARM_HI: begin
						if (above) begin
							state_d = ST_ARM_LO;
							tick_d  = '0;
						end
					end
					ST_ARM_LO: begin
						if (below) begin
							state_d = ST_TRACK_MIN;
							tick_d  = '0;
							ext_d   = s;
						end
					end
					ST_TRACK_MIN: begin
						if (s < ext_q) ext_d = s;
						if (above) begin
							state_d = ST_TRACK_MAX;
							tick_d  = '0;
							low_d   = (s < ext_q) ? s : ext_q;
						end
					end
					ST_TRACK_MAX: begin
						if (s > ext_q) ext_d = s;
						if (below) begin
							state_d = ST_TIME_LOW;
							tick_d  = '0;
							high_d  = (s > ext_q) ? s : ext_q;
						end
					end
					default: begin
						if (s < ext_q) ext_d = s;
						if (above) begin
							state_d        = ST_DONE;
							res.tune_valid = 1'b1;
							res.band       = {diff[BAND_W-2:0], 1'b0};
							res.integ      = tick_q;
							res.deriv      = prod[DIV10_SHIFT +: DERIV_W];
						end
					end
				endcase
			end
		end
		res.phase = phase_code(state_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ARM_HI;
			ext_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			tick_q  <= '0;
		end else if (en) begin
			state_q <= state_d;
			ext_q   <= ext_d;
			low_q   <= low_d;
			high_q  <= high_d;
			tick_q  <= tick_d;
		end
	end

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_DONE)
		else $error("done phase left before reset");

	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ERROR |=> state_q == ST_ERROR)
		else $error("error phase left before reset");

	a_tune_done: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.tune_valid |=> state_q == ST_DONE && $past(state_q) == ST_TIME_LOW)
		else $error("tuning result outside the timing phase");

	a_tick_restart: assert property (@(posedge clk) disable iff (!arst_n)
		en && state_q != state_d && state_d != ST_ERROR && state_d != ST_DONE
		|=> tick_q == '0)
		else $error("tick count not restarted on phase change");

endmodule

FILE: src/relay_autotune_oscillation_observer_core.sv
// Relay autotune oscillation observer, top level.
// A word is held in the input register, and its result word is then
// registered in the result register. One word per cycle while out_stall is low;
// the two registers let a new word in while a finished result waits under stall.
// Reset (arst_n low, asynchronous): phase 0, peaks and tick count zero,
// set point 0, band width 4, timeout 2000 ticks.
module relay_autotune_oscillation_observer_core import rot_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   cmd,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PHASE_W-1:0]     phase,
	output logic                   tune_valid,
	output logic [BAND_W-1:0]      band_out,
	output logic [INTEG_W-1:0]     integral_out,
	output logic [DERIV_W-1:0]     derivative_out,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DAT_W-1:0]   cfg_data
);

	localparam int TW = ((SAMPLE_BITS > SP_W) ? SAMPLE_BITS : SP_W) + 2;

	logic                   v_s1;
	logic                   cmd_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   out_valid_q;
	result_t                res_q;
	result_t                res;
	logic                   adv;
	logic signed [TW-1:0]   hi_thr, lo_thr;
	logic [TO_W-1:0]        timeout;

	assign cfg_ready = 1'b1;

	rot_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.hi_thr    (hi_thr),
		.lo_thr    (lo_thr),
		.timeout   (timeout)
	);

	// stage 1 word moves on when the result register is empty or being drained
	assign adv      = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && !adv;

	rot_phase_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.cmd     (cmd_s1),
		.sample  (sample_s1),
		.hi_thr  (hi_thr),
		.lo_thr  (lo_thr),
		.timeout (timeout),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1    <= cmd;
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign phase          = res_q.phase;
	assign tune_valid     = res_q.tune_valid;
	assign band_out       = res_q.band;
	assign integral_out   = res_q.integ;
	assign derivative_out = res_q.deriv;

endmodule
